// ===== sv/pixel_blend_arithmetic_defines.svh =====
// Assertion macros shared by the pixel blend RTL.
`ifndef PIXEL_BLEND_ARITHMETIC_DEFINES_SVH
`define PIXEL_BLEND_ARITHMETIC_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define PBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/pba_pkg.sv =====
// Shared constants and link type for the pixel blend datapath.
package pba_pkg;

   localparam int SampleWidth = 8;
   localparam int ModeWidth   = 2;
   localparam int DivSteps    = SampleWidth;
   localparam int AddrWidth   = 3;
   localparam int DataWidth   = 32;

   localparam logic [ModeWidth-1:0] ModeAdd = 2'd0;
   localparam logic [ModeWidth-1:0] ModeSub = 2'd1;
   localparam logic [ModeWidth-1:0] ModeMul = 2'd2;
   localparam logic [ModeWidth-1:0] ModeDiv = 2'd3;

   localparam logic [SampleWidth-1:0] SampleMax = 8'hFF;

   // register index as decoded from paddr[2]
   localparam logic RegBlendMode = 1'b0;

   // beat handed from cell to cell
   typedef struct packed {
      logic                   vld;
      logic [ModeWidth-1:0]   mode;
      logic [SampleWidth-1:0] alt;      // add/sub/mul result
      logic                   sat;      // divide saturates to max
      logic [SampleWidth-1:0] rem;      // partial remainder
      logic [SampleWidth-1:0] dq;       // dividend bits out, quotient bits in
      logic [SampleWidth-1:0] divisor;
   } link_type;

endpackage

// ===== sv/pba_front.sv =====
// Entry cell: add, subtract and multiply results, divide setup.
module pba_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               take,
   input  logic [pba_pkg::SampleWidth-1:0]    pixel_a,
   input  logic [pba_pkg::SampleWidth-1:0]    pixel_b,
   input  logic [pba_pkg::ModeWidth-1:0]      mode,
   output pba_pkg::link_type                  link_out
);

   localparam int SW = pba_pkg::SampleWidth;

   pba_pkg::link_type link_ff;
   pba_pkg::link_type link_in;

   logic [SW:0]       sum;
   logic [2*SW-1:0]   prod;
   logic [2*SW:0]     prod_adj;
   logic [2*SW-1:0]   scaled_a;
   logic [SW-1:0]     alt;

   always_comb begin
      sum      = {1'b0, pixel_a} + {1'b0, pixel_b};
      prod     = {{SW{1'b0}}, pixel_a} * {{SW{1'b0}}, pixel_b};
      // x/255 == (x + 1 + (x >> 8)) >> 8 over the 8x8 product range
      prod_adj = {1'b0, prod} + {{2*SW{1'b0}}, 1'b1}
               + {{(SW+1){1'b0}}, prod[2*SW-1:SW]};
      // a*255 = (a << 8) - a
      scaled_a = {pixel_a, {SW{1'b0}}} - {{SW{1'b0}}, pixel_a};

      unique case (mode)
         pba_pkg::ModeAdd: alt = sum[SW] ? pba_pkg::SampleMax : sum[SW-1:0];
         pba_pkg::ModeSub: alt = (pixel_a > pixel_b) ? (pixel_a - pixel_b) : '0;
         pba_pkg::ModeMul: alt = prod_adj[2*SW-1:SW];
         pba_pkg::ModeDiv: alt = '0;
         default:          alt = '0;
      endcase

      link_in.vld     = take;
      link_in.mode    = mode;
      link_in.alt     = alt;
      // b == 0, or a >= b gives a quotient of 255 or more
      link_in.sat     = (pixel_b == '0) || (pixel_a >= pixel_b);
      link_in.rem     = scaled_a[2*SW-1:SW];
      link_in.dq      = scaled_a[SW-1:0];
      link_in.divisor = pixel_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.vld <= 1'b0;
      end else begin
         link_ff.vld <= link_in.vld;
      end
      link_ff.mode    <= link_in.mode;
      link_ff.alt     <= link_in.alt;
      link_ff.sat     <= link_in.sat;
      link_ff.rem     <= link_in.rem;
      link_ff.dq      <= link_in.dq;
      link_ff.divisor <= link_in.divisor;
   end

   assign link_out = link_ff;

endmodule

// ===== sv/pba_div_cell.sv =====
// One restoring-division step: one quotient bit per cell.
`include "pixel_blend_arithmetic_defines.svh"

module pba_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  pba_pkg::link_type up_link,
   output pba_pkg::link_type link_out
);

   localparam int SW = pba_pkg::SampleWidth;

   pba_pkg::link_type link_ff;
   pba_pkg::link_type link_in;

   logic [SW:0] trial;
   logic [SW:0] diff;
   logic        ge;

   always_comb begin
      trial = {up_link.rem, up_link.dq[SW-1]};
      diff  = trial - {1'b0, up_link.divisor};
      ge    = trial >= {1'b0, up_link.divisor};

      link_in     = up_link;
      link_in.rem = ge ? diff[SW-1:0] : trial[SW-1:0];
      link_in.dq  = {up_link.dq[SW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.vld <= 1'b0;
      end else begin
         link_ff.vld <= link_in.vld;
      end
      link_ff.mode    <= link_in.mode;
      link_ff.alt     <= link_in.alt;
      link_ff.sat     <= link_in.sat;
      link_ff.rem     <= link_in.rem;
      link_ff.dq      <= link_in.dq;
      link_ff.divisor <= link_in.divisor;
   end

   assign link_out = link_ff;

   // partial remainder stays below the divisor on a live divide
   `PBA_ASSERT_SAME(a_rem_below_div, clock, reset, link_ff.vld && (link_ff.mode == pba_pkg::ModeDiv) && !link_ff.sat, link_ff.rem < link_ff.divisor, "remainder not below divisor")

endmodule

// ===== sv/pixel_blend_arithmetic.sv =====
// Top level of the saturating 8-bit pixel blend.
// ---------------------------------------------------------------------------
// Usage
//   Input: drive req_pixel_a / req_pixel_b with start high; the pair is taken
//   at any edge where start is high and busy is low. busy is always low, so
//   a new pair can go in on every clock.
//   Output: one result per pair, on rsp_pixel_out for one cycle while
//   rsp_valid is high. Results come back in input order.
//   Path: entry cell, eight division cells, output register, from the
//   accepting edge to the rsp_valid cycle. Throughput is one pair per
//   clock in every mode; the divide runs as a row of eight cells, one
//   quotient bit each, with all modes taking the same path length.
//   Config: blend_mode at byte address 0 on the APB port (0 add, 1 subtract,
//   2 multiply over 255, 3 divide scaled by 255). pready is tied high.
//   Change the mode only while no beat is in flight.
//   Reset (synchronous): clears blend_mode to add and drops every beat in
//   flight. The receiver cannot stall: rsp_valid must be taken when shown.
// ---------------------------------------------------------------------------
`include "pixel_blend_arithmetic_defines.svh"

module pixel_blend_arithmetic (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                start,
   output logic                                busy,
   input  logic [pba_pkg::SampleWidth-1:0]     req_pixel_a,
   input  logic [pba_pkg::SampleWidth-1:0]     req_pixel_b,
   // result channel
   output logic                                rsp_valid,
   output logic [pba_pkg::SampleWidth-1:0]     rsp_pixel_out,
   // config port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pba_pkg::AddrWidth-1:0]       paddr,
   input  logic [pba_pkg::DataWidth-1:0]       pwdata,
   output logic [pba_pkg::DataWidth-1:0]       prdata,
   output logic                                pready
);

   localparam int SW = pba_pkg::SampleWidth;
   localparam int MW = pba_pkg::ModeWidth;

   // ---- config register ----
   logic [MW-1:0] blend_mode_ff;
   logic [MW-1:0] blend_mode_in;
   logic          csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                && (paddr[pba_pkg::AddrWidth-1] == pba_pkg::RegBlendMode);

   always_comb begin
      blend_mode_in = blend_mode_ff;
      if (csr_wr) begin
         blend_mode_in = pwdata[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= pba_pkg::ModeAdd;
      end else begin
         blend_mode_ff <= blend_mode_in;
      end
   end

   // only one register; anything past it reads zero
   assign prdata = (paddr[pba_pkg::AddrWidth-1] == pba_pkg::RegBlendMode)
                 ? {{(pba_pkg::DataWidth-MW){1'b0}}, blend_mode_ff}
                 : '0;

   // ---- datapath: entry cell then division row ----
   logic take;
   assign busy = 1'b0;
   assign take = start && !busy;

   pba_pkg::link_type chain [0:pba_pkg::DivSteps];

   pba_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .pixel_a  (req_pixel_a),
      .pixel_b  (req_pixel_b),
      .mode     (blend_mode_ff),
      .link_out (chain[0])
   );

   for (genvar gi = 0; gi < pba_pkg::DivSteps; gi++) begin : g_cell
      pba_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_link  (chain[gi]),
         .link_out (chain[gi+1])
      );
   end

   // ---- result pick and output register ----
   pba_pkg::link_type tail;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [SW-1:0]     rsp_pixel_out_ff;
   logic [SW-1:0]     rsp_pixel_out_in;

   assign tail = chain[pba_pkg::DivSteps];

   always_comb begin
      rsp_valid_in = tail.vld;
      if (tail.mode == pba_pkg::ModeDiv) begin
         rsp_pixel_out_in = tail.sat ? pba_pkg::SampleMax : tail.dq;
      end else begin
         rsp_pixel_out_in = tail.alt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_out_ff <= rsp_pixel_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_out_ff;

   // every beat leaving the row shows up as a strobe
   `PBA_ASSERT_NEXT(a_tail_strobes, clock, reset, tail.vld, rsp_valid, "beat lost at output")
   // saturated divide lands as full scale
   `PBA_ASSERT_NEXT(a_div_sat_max, clock, reset, tail.vld && (tail.mode == pba_pkg::ModeDiv) && tail.sat, rsp_pixel_out == pba_pkg::SampleMax, "divide saturation lost")

endmodule

// ===== bench/pixel_blend_arithmetic_tb.sv =====
// Self-checking testbench for the saturating 8-bit pixel blend block.
`timescale 1ns / 100ps

module pixel_blend_arithmetic_tb;

   localparam int SW = pba_pkg::SampleWidth;
   localparam int MW = pba_pkg::ModeWidth;
   localparam int AW = pba_pkg::AddrWidth;
   localparam int DW = pba_pkg::DataWidth;

   // accept edge to rsp_valid cycle; sizes the final drain wait
   localparam int PIPE_LATENCY = 10;
   localparam int DRAIN_CYCLES = PIPE_LATENCY + 6;
   localparam int RAND_PER_PHASE = 584;
   localparam int NUM_DIRECTED = 23;

   localparam logic [AW-1:0] ModeAddr  = {pba_pkg::RegBlendMode, 2'b00};
   // next word up decodes to no register; writes there must be dropped
   localparam logic [AW-1:0] SpareAddr = {~pba_pkg::RegBlendMode, 2'b00};

   typedef struct packed {
      logic [MW-1:0] mode;
      logic [SW-1:0] pixel_a;
      logic [SW-1:0] pixel_b;
      logic [SW-1:0] pixel_out;
      logic          known;     // pixel_out typed in, else predicted
   } blend_vec_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [SW-1:0] req_pixel_a;
   logic [SW-1:0] req_pixel_b;
   logic          rsp_valid;
   logic [SW-1:0] rsp_pixel_out;
   logic          psel;
   logic          penable;
   logic          pwrite;
   logic [AW-1:0] paddr;
   logic [DW-1:0] pwdata;
   logic [DW-1:0] prdata;
   logic          pready;

   // expected blended samples, oldest first
   logic [SW-1:0] pending_pixels [$];
   // blend_mode as the block should hold it
   logic [MW-1:0] cur_mode;
   // percent of cycles the sender sits idle
   int            gap_pct;
   int            fail_count;

   // Directed vectors. Saturation and clamp corners carry their answer;
   // the middle-of-range multiply/divide rows go through the predictor.
   // The opening add rows run before any mode write, so they also
   // confirm the reset value of blend_mode.
   blend_vec_type dir_vecs [NUM_DIRECTED] = '{
      '{pba_pkg::ModeAdd, 8'd0,   8'd0,   8'd0,   1'b1},
      '{pba_pkg::ModeAdd, 8'd255, 8'd255, 8'd255, 1'b1},
      '{pba_pkg::ModeAdd, 8'd200, 8'd100, 8'd255, 1'b1},
      '{pba_pkg::ModeAdd, 8'd128, 8'd127, 8'd255, 1'b1},
      '{pba_pkg::ModeAdd, 8'd100, 8'd50,  8'd150, 1'b1},
      '{pba_pkg::ModeSub, 8'd0,   8'd255, 8'd0,   1'b1},
      '{pba_pkg::ModeSub, 8'd255, 8'd0,   8'd255, 1'b1},
      '{pba_pkg::ModeSub, 8'd100, 8'd100, 8'd0,   1'b1},
      '{pba_pkg::ModeSub, 8'd50,  8'd60,  8'd0,   1'b1},
      '{pba_pkg::ModeSub, 8'd200, 8'd73,  8'd127, 1'b1},
      '{pba_pkg::ModeMul, 8'd255, 8'd255, 8'd255, 1'b1},
      '{pba_pkg::ModeMul, 8'd0,   8'd255, 8'd0,   1'b1},
      '{pba_pkg::ModeMul, 8'd255, 8'd1,   8'd1,   1'b1},
      '{pba_pkg::ModeMul, 8'd128, 8'd128, 8'd0,   1'b0},
      '{pba_pkg::ModeMul, 8'd17,  8'd200, 8'd0,   1'b0},
      '{pba_pkg::ModeDiv, 8'd5,   8'd0,   8'd255, 1'b1},
      '{pba_pkg::ModeDiv, 8'd0,   8'd0,   8'd255, 1'b1},
      '{pba_pkg::ModeDiv, 8'd200, 8'd100, 8'd255, 1'b1},
      '{pba_pkg::ModeDiv, 8'd0,   8'd7,   8'd0,   1'b1},
      '{pba_pkg::ModeDiv, 8'd255, 8'd255, 8'd255, 1'b1},
      '{pba_pkg::ModeDiv, 8'd1,   8'd255, 8'd1,   1'b1},
      '{pba_pkg::ModeDiv, 8'd100, 8'd200, 8'd0,   1'b0},
      '{pba_pkg::ModeDiv, 8'd37,  8'd91,  8'd0,   1'b0}
   };

   pixel_blend_arithmetic DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_a   (req_pixel_a),
      .req_pixel_b   (req_pixel_b),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   // Blend predictor: one sample pair under the given mode.
   function automatic logic [SW-1:0] blend_pixel(
      input logic [MW-1:0] mode,
      input logic [SW-1:0] a,
      input logic [SW-1:0] b);
      int unsigned full_scale;
      int unsigned ua;
      int unsigned ub;
      int unsigned r;
      full_scale = 32'(pba_pkg::SampleMax);
      ua = 32'(a);
      ub = 32'(b);
      case (mode)
         pba_pkg::ModeAdd: r = ua + ub;
         pba_pkg::ModeSub: r = (ua > ub) ? ua - ub : 0;
         pba_pkg::ModeMul: r = (ua * ub) / full_scale;
         default:          r = (ub == 0) ? full_scale : (ua * full_scale) / ub;
      endcase
      if (r > full_scale)
         r = full_scale;
      return r[SW-1:0];
   endfunction

   // Corner values a quarter of the time, uniform otherwise.
   function automatic logic [SW-1:0] pick_sample();
      logic [SW-1:0] corner [4];
      corner = '{8'd0, 8'd1, 8'd254, 8'd255};
      if ($urandom_range(0, 3) == 0)
         return corner[2'($urandom_range(0, 3))];
      return SW'($urandom_range(0, 255));
   endfunction

   // Two-phase APB write; pready is sampled on the access edge.
   task automatic write_csr(input logic [AW-1:0] addr,
                            input logic [DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // only paddr[2] decodes; upper data bits are dropped by the block
      if (addr[AW-1] == pba_pkg::RegBlendMode)
         cur_mode = data[MW-1:0];
   endtask

   // Stop feeding, let the pipe empty, then change the mode. Every beat
   // yields a result, so an empty queue means nothing is in flight.
   task automatic set_mode(input logic [MW-1:0] mode);
      logic [DW-1:0] data;
      start <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      data = $urandom;
      data[MW-1:0] = mode;
      write_csr(ModeAddr, data);
   endtask

   // Hand one pair to the block and log what should come back.
   task automatic send_pair(input logic [SW-1:0] a,
                            input logic [SW-1:0] b,
                            input logic          known,
                            input logic [SW-1:0] typed_out);
      // each cycle idles with probability gap_pct percent
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_pixel_a <= a;
      req_pixel_b <= b;
      // busy read here is its value just before this edge
      do @(posedge clock); while (busy);
      pending_pixels.push_back(known ? typed_out : blend_pixel(cur_mode, a, b));
   endtask

   // Result checker: the receiver cannot stall, so every rsp_valid cycle
   // is a beat taken.
   always @(posedge clock) begin
      logic [SW-1:0] want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel_out beat with no expectation: actual %0d", rsp_pixel_out);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_out !== want) begin
               $error("pixel_out mismatch: expected %0d, actual %0d", want, rsp_pixel_out);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int left;
      logic [MW-1:0] next_mode;
      fail_count   = 0;
      gap_pct      = 0;
      cur_mode     = pba_pkg::ModeAdd;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_pixel_a <= '0;
      req_pixel_b <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      foreach (dir_vecs[i]) begin
         if (dir_vecs[i].mode != cur_mode)
            set_mode(dir_vecs[i].mode);
         send_pair(dir_vecs[i].pixel_a, dir_vecs[i].pixel_b,
                   dir_vecs[i].known, dir_vecs[i].pixel_out);
      end

      // random traffic in three pacing phases: light gaps, heavy gaps, none
      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 11 : (phase == 1) ? 51 : 0;
         left = RAND_PER_PHASE;
         // first block of phases 0 and 2 pins the end codes of the register
         while (left > 0) begin
            if (left == RAND_PER_PHASE && phase != 1)
               next_mode = (phase == 0) ? pba_pkg::ModeDiv : pba_pkg::ModeAdd;
            else
               next_mode = MW'($urandom_range(0, 3));
            set_mode(next_mode);
            // stray write to the unmapped word: mode must stay put
            if ($urandom_range(0, 3) == 0)
               write_csr(SpareAddr, $urandom);
            for (int n = $urandom_range(20, 80); n > 0 && left > 0; n--) begin
               send_pair(pick_sample(), pick_sample(), 1'b0, '0);
               left--;
            end
         end
      end

      start <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      // catch any stray beat past the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
